>>> hw/rtl/tmra_pkg.sv
package tmra_pkg;

   localparam int MAP_SIDE      = 512;
   localparam int COUNT_BITS    = 16;
   localparam int SIDE_BITS     = $clog2(MAP_SIDE);
   localparam int CELLS         = MAP_SIDE * MAP_SIDE;
   localparam int ADDR_BITS     = $clog2(CELLS);
   localparam int COORD_BITS    = ((SIDE_BITS > 9) ? SIDE_BITS : 9) + 1;
   localparam int SUM_BITS      = COUNT_BITS + 8;
   localparam int NUM_BITS      = SUM_BITS + 1;
   localparam int DIV_STAGES    = 8;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   localparam logic REG_ALPHA_THRESHOLD = 1'b0;

   typedef struct packed {
      logic [SUM_BITS-1:0]   sum_c2;
      logic [SUM_BITS-1:0]   sum_c1;
      logic [SUM_BITS-1:0]   sum_c0;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                         valid;
      logic                         zero;
      logic [COUNT_BITS-1:0]        count;
      logic [2:0]                   sat;
      logic [2:0][NUM_BITS-1:0]     rem;
      logic [2:0][7:0]              quo;
   } div_type;

endpackage

>>> hw/rtl/tmra_req_if.sv
interface tmra_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] row;
   logic [8:0] col;
   logic [7:0] new_c0;
   logic [7:0] new_c1;
   logic [7:0] new_c2;
   logic [7:0] new_alpha;

   modport source (output valid, row, col, new_c0, new_c1, new_c2, new_alpha, input ready);
   modport sink (input valid, row, col, new_c0, new_c1, new_c2, new_alpha, output ready);
endinterface

>>> hw/rtl/tmra_rsp_if.sv
interface tmra_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] merged_c0;
   logic [7:0] merged_c1;
   logic [7:0] merged_c2;
   logic [7:0] merged_alpha;

   modport source (output valid, merged_c0, merged_c1, merged_c2, merged_alpha, input ready);
   modport sink (input valid, merged_c0, merged_c1, merged_c2, merged_alpha, output ready);
endinterface

>>> hw/rtl/tmra_ram.sv
module tmra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

>>> hw/rtl/texture_map_running_average.sv
// Per-position running average of texture pixels, gated by alpha.
// req_ch: one transaction per pixel (row, col, three colors, alpha).
// rsp_ch: one transaction per request, in order: the rounded channel
//   averages at that position and alpha 255 once the position was merged.
// csr: APB-style port; register 0 (byte address 0) is alpha_threshold.
//   A pixel is merged only if its alpha is above the threshold.
// Throughput: one transaction per cycle while rsp_ch does not stall. A request
//   passes the memory read, the update stage, the divider input register and
//   an 8-stage restoring divider (one quotient bit per stage).
// Sums and counts live in one single-port-write memory with registered
//   read; the last write is forwarded so back-to-back hits on one position
//   see fresh data.
// Reset: alpha_threshold goes to 0 and a clearing sweep writes zero to
//   all MAP_SIDE*MAP_SIDE entries, one per cycle; req_ch ready stays low during
//   the sweep, csr writes are still taken.
// When rsp_ch stalls the whole pipeline holds and req_ch ready drops.
module texture_map_running_average
   import tmra_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   tmra_req_if.sink                 req_ch,
   tmra_rsp_if.source               rsp_ch,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [7:0]           thr_ff;
   logic                 clr_ff;
   logic [ADDR_BITS-1:0] clr_addr_ff;

   logic                 adv;
   logic                 accept;
   logic [COORD_BITS-1:0] row_w;
   logic [COORD_BITS-1:0] col_w;
   logic                 req_in_map;
   logic [ADDR_BITS-1:0] req_idx;

   logic                 s1_valid_ff;
   logic                 s1_in_map_ff;
   logic                 s1_hit_ff;
   logic [ADDR_BITS-1:0] s1_addr_ff;
   logic [7:0]           s1_c0_ff;
   logic [7:0]           s1_c1_ff;
   logic [7:0]           s1_c2_ff;

   logic                 fw_valid_ff;
   logic [ADDR_BITS-1:0] fw_addr_ff;
   entry_type            fw_data_ff;

   entry_type            ram_rdata;
   entry_type            cur;
   entry_type            upd_in;
   logic                 do_upd;
   logic                 wr_item;

   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_waddr;
   entry_type            ram_wdata;

   logic                 s2_valid_ff;
   logic                 s2_in_map_ff;
   entry_type            s2_entry_ff;

   div_type              d_ff [DIV_STAGES+1];
   div_type              d_in [DIV_STAGES+1];

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_ALPHA_THRESHOLD) ? {24'd0, thr_ff} : 32'd0;

   assign adv           = !d_ff[DIV_STAGES].valid || rsp_ch.ready;
   assign req_ch.ready  = adv && !clr_ff;
   assign accept        = req_ch.valid && req_ch.ready;

   always_comb begin
      row_w      = COORD_BITS'(req_ch.row);
      col_w      = COORD_BITS'(req_ch.col);
      req_in_map = (row_w < COORD_BITS'(MAP_SIDE)) && (col_w < COORD_BITS'(MAP_SIDE));
      req_idx    = ADDR_BITS'(row_w) * ADDR_BITS'(MAP_SIDE) + ADDR_BITS'(col_w);
   end

   always_comb begin
      cur     = (fw_valid_ff && fw_addr_ff == s1_addr_ff) ? fw_data_ff : ram_rdata;
      do_upd  = s1_hit_ff && s1_in_map_ff && (cur.count != COUNT_MAX);
      upd_in  = cur;
      if (do_upd) begin
         upd_in.sum_c0 = cur.sum_c0 + SUM_BITS'(s1_c0_ff);
         upd_in.sum_c1 = cur.sum_c1 + SUM_BITS'(s1_c1_ff);
         upd_in.sum_c2 = cur.sum_c2 + SUM_BITS'(s1_c2_ff);
         upd_in.count  = cur.count + COUNT_BITS'(1);
      end
      wr_item   = s1_valid_ff && do_upd && adv;
      ram_we    = clr_ff || wr_item;
      ram_waddr = clr_ff ? clr_addr_ff : s1_addr_ff;
      ram_wdata = clr_ff ? '0 : upd_in;
   end

   tmra_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (adv),
      .raddr (req_idx),
      .rdata (ram_rdata)
   );

   always_comb begin
      d_in[0].valid  = s2_valid_ff;
      d_in[0].zero   = !s2_in_map_ff || (s2_entry_ff.count == '0);
      d_in[0].count  = s2_entry_ff.count;
      d_in[0].quo    = '0;
      d_in[0].rem[0] = NUM_BITS'(s2_entry_ff.sum_c0) + NUM_BITS'(s2_entry_ff.count >> 1);
      d_in[0].rem[1] = NUM_BITS'(s2_entry_ff.sum_c1) + NUM_BITS'(s2_entry_ff.count >> 1);
      d_in[0].rem[2] = NUM_BITS'(s2_entry_ff.sum_c2) + NUM_BITS'(s2_entry_ff.count >> 1);
      for (int i = 0; i < 3; i++) begin
         d_in[0].sat[i] = d_in[0].rem[i] >= (NUM_BITS'(s2_entry_ff.count) << 8);
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         d_in[k+1] = d_ff[k];
         for (int i = 0; i < 3; i++) begin
            if (d_ff[k].rem[i] >= (NUM_BITS'(d_ff[k].count) << (DIV_STAGES - 1 - k))) begin
               d_in[k+1].rem[i] = d_ff[k].rem[i]
                  - (NUM_BITS'(d_ff[k].count) << (DIV_STAGES - 1 - k));
               d_in[k+1].quo[i][DIV_STAGES-1-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= '0;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         fw_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         for (int k = 0; k <= DIV_STAGES; k++) begin
            d_ff[k].valid <= 1'b0;
         end
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == REG_ALPHA_THRESHOLD) begin
            thr_ff <= csr_pwdata[7:0];
         end
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == ADDR_BITS'(CELLS - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (wr_item) begin
            fw_valid_ff <= 1'b1;
            fw_addr_ff  <= s1_addr_ff;
            fw_data_ff  <= upd_in;
         end
         if (adv) begin
            s1_valid_ff  <= accept;
            s1_in_map_ff <= req_in_map;
            s1_hit_ff    <= req_ch.new_alpha > thr_ff;
            s1_addr_ff   <= req_idx;
            s1_c0_ff     <= req_ch.new_c0;
            s1_c1_ff     <= req_ch.new_c1;
            s1_c2_ff     <= req_ch.new_c2;
            s2_valid_ff  <= s1_valid_ff;
            s2_in_map_ff <= s1_in_map_ff;
            s2_entry_ff  <= upd_in;
            for (int k = 0; k <= DIV_STAGES; k++) begin
               d_ff[k] <= d_in[k];
            end
         end
      end
   end

   assign rsp_ch.valid        = d_ff[DIV_STAGES].valid;
   assign rsp_ch.merged_c0    = d_ff[DIV_STAGES].zero ? 8'd0 :
                                d_ff[DIV_STAGES].sat[0] ? 8'd255 : d_ff[DIV_STAGES].quo[0];
   assign rsp_ch.merged_c1    = d_ff[DIV_STAGES].zero ? 8'd0 :
                                d_ff[DIV_STAGES].sat[1] ? 8'd255 : d_ff[DIV_STAGES].quo[1];
   assign rsp_ch.merged_c2    = d_ff[DIV_STAGES].zero ? 8'd0 :
                                d_ff[DIV_STAGES].sat[2] ? 8'd255 : d_ff[DIV_STAGES].quo[2];
   assign rsp_ch.merged_alpha = d_ff[DIV_STAGES].zero ? 8'd0 : 8'd255;

endmodule

>>> sim/tb_texture_map_running_average.sv
module tb_texture_map_running_average
   import tmra_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int DRAIN_WAIT  = 20;
   localparam int N_RANDOM    = 340;
   localparam int BURST_ITEMS = 40;

   typedef struct packed {
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [7:0] alpha;
   } merged_pixel_type;

   class pixel_merge_board;
      int unsigned      sum0[int];
      int unsigned      sum1[int];
      int unsigned      sum2[int];
      int unsigned      seen[int];
      logic [7:0]       threshold;
      merged_pixel_type expected_pixels[$];
      int               errors;
      int               n_pixels;
      int               n_merged;
      int               n_checked;

      function new();
         threshold = 8'd0;
         errors    = 0;
         n_pixels  = 0;
         n_merged  = 0;
         n_checked = 0;
      endfunction

      function logic [7:0] average(int unsigned sum, int unsigned n);
         longint unsigned q;
         if (n == 0) return 8'd0;
         q = (longint'(sum) + n / 2) / n;
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      function void note_pixel(logic [8:0] row, logic [8:0] col, logic [7:0] c0,
                               logic [7:0] c1, logic [7:0] c2, logic [7:0] alpha);
         int               idx;
         int unsigned      n;
         merged_pixel_type m;
         idx = row * MAP_SIDE + col;
         if (!seen.exists(idx)) begin
            sum0[idx] = 0;
            sum1[idx] = 0;
            sum2[idx] = 0;
            seen[idx] = 0;
         end
         n_pixels++;
         if (alpha > threshold && seen[idx] < COUNT_MAX) begin
            sum0[idx] += c0;
            sum1[idx] += c1;
            sum2[idx] += c2;
            seen[idx] += 1;
            n_merged++;
         end
         n    = seen[idx];
         m.c0 = average(sum0[idx], n);
         m.c1 = average(sum1[idx], n);
         m.c2 = average(sum2[idx], n);
         m.alpha = (n != 0) ? 8'd255 : 8'd0;
         expected_pixels.insert(expected_pixels.size(), m);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_merged(merged_pixel_type got);
         merged_pixel_type exp;
         if (expected_pixels.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         exp = expected_pixels.pop_front();
         n_checked++;
         if (got.c0 !== exp.c0)
            report($sformatf("merged_c0 got %0d exp %0d", got.c0, exp.c0));
         if (got.c1 !== exp.c1)
            report($sformatf("merged_c1 got %0d exp %0d", got.c1, exp.c1));
         if (got.c2 !== exp.c2)
            report($sformatf("merged_c2 got %0d exp %0d", got.c2, exp.c2));
         if (got.alpha !== exp.alpha)
            report($sformatf("merged_alpha got %0d exp %0d", got.alpha, exp.alpha));
      endtask
   endclass

   logic clock;
   logic reset;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   tmra_req_if req_ch();
   tmra_rsp_if rsp_ch();

   texture_map_running_average u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pixel_merge_board board = new();
   bit  rx_no_stall;
   bit  tx_no_gap;
   int  cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycles,
                  board.expected_pixels.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         board.note_pixel(req_ch.row, req_ch.col, req_ch.new_c0, req_ch.new_c1,
                          req_ch.new_c2, req_ch.new_alpha);
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_merged({rsp_ch.merged_c0, rsp_ch.merged_c1,
                             rsp_ch.merged_c2, rsp_ch.merged_alpha});
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response-side backpressure
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (rx_no_stall) begin
            rsp_ch.ready = 1'b1;
            stall = 0;
         end else if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            stall--;
         end else begin
            rsp_ch.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   task send_pixel(logic [8:0] row, logic [8:0] col, logic [7:0] c0, logic [7:0] c1,
                   logic [7:0] c2, logic [7:0] alpha);
      int gap;
      @(negedge clock);
      req_ch.valid     = 1'b1;
      req_ch.row       = row;
      req_ch.col       = col;
      req_ch.new_c0    = c0;
      req_ch.new_c1    = c1;
      req_ch.new_c2    = c2;
      req_ch.new_alpha = alpha;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      gap = tx_no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task drop_valid();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task wait_idle();
      drop_valid();
      while (board.expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (addr[2] == REG_ALPHA_THRESHOLD)
         board.threshold = data[7:0];
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task csr_check_threshold();
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = CSR_ADDR_BITS'(4 * REG_ALPHA_THRESHOLD);
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== board.threshold)
         board.report($sformatf("alpha_threshold read %0d exp %0d", csr_prdata[7:0],
                                board.threshold));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task set_threshold(logic [7:0] value);
      wait_idle();
      csr_write(CSR_ADDR_BITS'(4 * REG_ALPHA_THRESHOLD), {24'd0, value});
      csr_check_threshold();
   endtask

   task random_pixel();
      logic [8:0] row, col;
      if ($urandom_range(0, 2) != 0) begin
         row = 9'($urandom_range(0, 3));
         col = 9'($urandom_range(508, 511));
      end else begin
         row = 9'($urandom);
         col = 9'($urandom);
      end
      send_pixel(row, col, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      int i;
      reset            = 1'b1;
      rx_no_stall      = 1'b0;
      tx_no_gap        = 1'b0;
      req_ch.valid     = 1'b0;
      req_ch.row       = '0;
      req_ch.col       = '0;
      req_ch.new_c0    = '0;
      req_ch.new_c1    = '0;
      req_ch.new_c2    = '0;
      req_ch.new_alpha = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: never merged, alpha gate, extremes, back-to-back hits
      send_pixel(9'd0, 9'd0, 8'd255, 8'd255, 8'd255, 8'd0);
      send_pixel(9'd0, 9'd0, 8'd255, 8'd0, 8'd128, 8'd1);
      send_pixel(9'd0, 9'd0, 8'd0, 8'd255, 8'd127, 8'd255);
      send_pixel(9'd0, 9'd0, 8'd1, 8'd2, 8'd0, 8'd255);
      send_pixel(9'd511, 9'd511, 8'd0, 8'd0, 8'd0, 8'd255);
      send_pixel(9'd511, 9'd511, 8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(9'd511, 9'd0, 8'd170, 8'd85, 8'd1, 8'd200);
      send_pixel(9'd0, 9'd511, 8'd85, 8'd170, 8'd254, 8'd0);
      set_threshold(8'd255);
      send_pixel(9'd0, 9'd0, 8'd255, 8'd255, 8'd255, 8'd255);
      send_pixel(9'd1, 9'd1, 8'd255, 8'd255, 8'd255, 8'd255);
      // write to a register that does not exist must not change anything
      wait_idle();
      csr_write(3'd4, 32'd7);
      csr_check_threshold();
      send_pixel(9'd1, 9'd1, 8'd9, 8'd9, 8'd9, 8'd255);
      set_threshold(8'd128);
      send_pixel(9'd1, 9'd1, 8'd10, 8'd20, 8'd30, 8'd128);
      send_pixel(9'd1, 9'd1, 8'd10, 8'd20, 8'd30, 8'd129);
      send_pixel(9'd1, 9'd1, 8'd11, 8'd21, 8'd31, 8'd129);

      // burst of hits on one position, back to back
      set_threshold(8'd0);
      tx_no_gap   = 1'b1;
      rx_no_stall = 1'b1;
      for (i = 0; i < BURST_ITEMS; i++)
         send_pixel(9'd3, 9'd5, i[7:0], 8'd255, (i % 3 == 0) ? 8'd255 : 8'd0, 8'd1);
      tx_no_gap   = 1'b0;
      rx_no_stall = 1'b0;

      // random phases across several thresholds
      for (i = 0; i < N_RANDOM; i++) begin
         if (i % 100 == 0)
            set_threshold((i == 0) ? 8'd0 : 8'($urandom));
         if (i % 100 == 50) begin
            tx_no_gap   = ~tx_no_gap;
            rx_no_stall = ~rx_no_stall;
         end
         if (i == 250) wait_idle();
         if (i % 17 == 0)
            send_pixel(9'd3, 9'd5, 8'($urandom), 8'($urandom), 8'($urandom), 8'd255);
         else random_pixel();
      end
      tx_no_gap   = 1'b0;
      rx_no_stall = 1'b0;
      wait_idle();

      $display("covered %0d pixels (%0d merged), %0d results checked", board.n_pixels,
               board.n_merged, board.n_checked);
      $display("thresholds 0..255, repeated hits on one position and bad address write");
      if (board.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", board.errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> texture_map_running_average.f
hw/rtl/tmra_pkg.sv
hw/rtl/tmra_req_if.sv
hw/rtl/tmra_rsp_if.sv
hw/rtl/tmra_ram.sv
hw/rtl/texture_map_running_average.sv
sim/tb_texture_map_running_average.sv
